// File: sv/fmpa_pkg.sv
// ----------------------------------------------------------------------------
// fmpa_pkg
// Shared widths, constants and types of the frame averager.
// ----------------------------------------------------------------------------
package fmpa_pkg;

	localparam int DATA_W      = 8;
	localparam int POS_W       = 7;
	// running sum of up to 16 frames of 8-bit samples
	localparam int SUM_W       = 12;
	// shift of the reciprocal multiply; exact for SUM_W-bit sums and FRAMES <= 16
	localparam int RECIP_SHIFT = 24;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_CNT_W  = 3;

	typedef struct packed {
		logic              emit;
		logic              last;
		logic [POS_W-1:0]  pos;
	} tag_t;

	typedef struct packed {
		logic [DATA_W-1:0] avg;
		logic [POS_W-1:0]  pos;
		logic              last;
	} result_t;

endpackage

// File: sv/fmpa_ram.sv
// ----------------------------------------------------------------------------
// fmpa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fmpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 640
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/fmpa_div.sv
// ----------------------------------------------------------------------------
// fmpa_div
// Divides the running sum by FRAMES through a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module fmpa_div #(
	parameter int FRAMES = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [fmpa_pkg::SUM_W-1:0]       sum,
	input  fmpa_pkg::tag_t                   tag,
	output logic                             out_valid,
	output logic                             out_emit,
	output fmpa_pkg::result_t                res
);

	import fmpa_pkg::*;

	localparam int unsigned MAGIC_I = ((2 ** RECIP_SHIFT) + FRAMES - 1) / FRAMES;
	localparam logic [RECIP_SHIFT-1:0] MAGIC = RECIP_SHIFT'(MAGIC_I);
	localparam int PROD_W = SUM_W + RECIP_SHIFT;

	logic              v_s2;
	tag_t              tag_s2;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2  <= tag;
		prod_s2 <= PROD_W'(sum) * PROD_W'(MAGIC);
	end

	assign out_valid = v_s2;
	assign out_emit  = v_s2 & tag_s2.emit;
	assign res.avg   = prod_s2[RECIP_SHIFT +: DATA_W];
	assign res.pos   = tag_s2.pos;
	assign res.last  = tag_s2.last;

endmodule

// File: sv/fmpa_fifo.sv
// ----------------------------------------------------------------------------
// fmpa_fifo
// Small result queue that decouples the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module fmpa_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  fmpa_pkg::result_t               wdata,
	input  logic                            pop,
	output logic                            not_empty,
	output fmpa_pkg::result_t               rdata,
	output logic [fmpa_pkg::FIFO_CNT_W-1:0] count
);

	import fmpa_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	result_t           mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic              do_pop;

	assign do_pop = pop & (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	assign not_empty = (cnt_q != '0);
	assign rdata     = mem[rd_ptr_q];
	assign count     = cnt_q;

endmodule

// File: sv/multi_frame_pixel_averager.sv
// ----------------------------------------------------------------------------
// multi_frame_pixel_averager
// Temporal moving average of a line sensor over the last FRAMES frames.
// ----------------------------------------------------------------------------
// An accepted pixel passes the stage 1 registers and the divider register and is then queued in the result FIFO.
// Throughput: one pixel per cycle while in_ready is high, set by the history
// and running-sum RAMs (read at acceptance, written back in the next cycle).
// Reset clears the position, slot and frame counters; the RAMs are not
// cleared and unwritten entries are masked until each slot has been filled.
// ----------------------------------------------------------------------------
module multi_frame_pixel_averager #(
	parameter int PIXELS = 128,
	parameter int FRAMES = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fmpa_pkg::DATA_W-1:0]       pixel_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fmpa_pkg::DATA_W-1:0]       average_value,
	output logic [fmpa_pkg::POS_W-1:0]        pixel_position,
	output logic                              line_end
);

	import fmpa_pkg::*;

	localparam int PW    = $clog2(PIXELS);
	localparam int SW    = $clog2(FRAMES);
	localparam int HW    = $clog2(FRAMES + 1);
	localparam int DEPTH = FRAMES * PIXELS;
	localparam int AW    = $clog2(DEPTH);

	// position, slot and history base of the next pixel
	logic [PW-1:0] pos_q;
	logic [SW-1:0] slot_q;
	logic [AW-1:0] base_q;
	logic [HW-1:0] held_q;

	logic          accept;
	logic          last;
	logic [AW-1:0] hist_raddr;

	// stage 1: RAM data returns, sum is updated and written back
	logic          v_s1;
	logic [DATA_W-1:0] sample_s1;
	logic [AW-1:0] haddr_s1;
	logic [PW-1:0] pos_s1;
	logic          fresh_s1;
	logic          first_s1;
	tag_t          tag_s1;

	logic [DATA_W-1:0] hist_rd;
	logic [SUM_W-1:0]  sum_rd;
	logic [DATA_W-1:0] old_sample;
	logic [SUM_W-1:0]  old_sum;
	logic [SUM_W-1:0]  new_sum;

	logic [PW+POS_W-1:0] pos_ext;

	logic              v_s2;
	logic              emit_s2;
	result_t           res_s2;
	result_t           head;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [FIFO_CNT_W:0]   occ;

	assign accept     = in_valid & in_ready;
	assign last       = (pos_q == PW'(PIXELS - 1));
	assign hist_raddr = base_q + AW'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			slot_q <= '0;
			base_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				if (slot_q == SW'(FRAMES - 1)) begin
					slot_q <= '0;
					base_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
					base_q <= base_q + AW'(PIXELS);
				end
				if (held_q != HW'(FRAMES)) begin
					held_q <= held_q + 1'b1;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1   <= pixel_value;
		haddr_s1    <= hist_raddr;
		pos_s1      <= pos_q;
		// slot not yet written in this position: nothing to subtract
		fresh_s1    <= (held_q != HW'(FRAMES));
		// first frame: running sum not yet written
		first_s1    <= (held_q == '0);
		tag_s1.emit <= (held_q >= HW'(FRAMES - 1));
		tag_s1.last <= last;
		tag_s1.pos  <= pos_ext[POS_W-1:0];
	end

	assign pos_ext = (PW + POS_W)'(pos_q);

	fmpa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (v_s1),
		.waddr (haddr_s1),
		.wdata (sample_s1),
		.raddr (hist_raddr),
		.rdata (hist_rd)
	);

	fmpa_ram #(
		.WIDTH (SUM_W),
		.DEPTH (PIXELS)
	) u_sum (
		.clk   (clk),
		.we    (v_s1),
		.waddr (pos_s1),
		.wdata (new_sum),
		.raddr (pos_q),
		.rdata (sum_rd)
	);

	// same position recurs no sooner than PIXELS >= 2 pixels later, after write-back
	assign old_sample = fresh_s1 ? '0 : hist_rd;
	assign old_sum    = first_s1 ? '0 : sum_rd;
	assign new_sum    = old_sum - SUM_W'(old_sample) + SUM_W'(sample_s1);

	fmpa_div #(
		.FRAMES (FRAMES)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.sum       (new_sum),
		.tag       (tag_s1),
		.out_valid (v_s2),
		.out_emit  (emit_s2),
		.res       (res_s2)
	);

	fmpa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s2),
		.wdata     (res_s2),
		.pop       (out_ready),
		.not_empty (out_valid),
		.rdata     (head),
		.count     (fifo_cnt)
	);

	// reserve a queue slot for every transaction still in the pipeline
	assign occ      = (FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'(v_s1)
	                + (FIFO_CNT_W + 1)'(v_s2);
	assign in_ready = (occ < (FIFO_CNT_W + 1)'(FIFO_DEPTH));

	assign average_value  = head.avg;
	assign pixel_position = head.pos;
	assign line_end       = head.last;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
		else $error("result queue overcommitted");

	a_emit_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && tag_s1.emit) |-> !first_s1)
		else $error("average formed before history filled");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2)
		else $error("pipeline lost a transaction");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (slot_q <= SW'(FRAMES - 1)) && (pos_q == '0))
		else $error("ring slot out of range after line end");

endmodule

// File: tb/tb_multi_frame_pixel_averager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_frame_pixel_averager
// Self-checking bench for the temporal line averager. Whole frames are
// streamed through the valid/ready input. Every average that comes out is
// compared with a cycle-free ring model in the bench or with a typed plan row.
// A short plan of directed frames covers warm-up, extremes and line wrap.
// Random frames of mixed content follow, with bursty idling on both sides.
// ----------------------------------------------------------------------------
module tb_multi_frame_pixel_averager;
	import fmpa_pkg::*;

	localparam int PIXELS       = 128;
	localparam int FRAMES       = 5;
	localparam int RAND_ITEMS   = 880;
	localparam int CALM_TAIL    = 200;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 12;

	typedef enum logic [1:0] {FILL_CONST, FILL_RAMP, FILL_CHECKER} fill_t;

	typedef struct {
		fill_t             kind;
		logic [DATA_W-1:0] val;
		bit                typed;   // expected result given in the row
		bit                emits;
		logic [DATA_W-1:0] avg;
	} frame_row_t;

	localparam int N_ROWS = 8;

	// warm-up frames carry no result; five full-scale frames average to full scale
	frame_row_t frame_plan [N_ROWS] = '{
		'{FILL_CONST,   8'hFF, 1'b1, 1'b0, 8'h00},
		'{FILL_CONST,   8'hFF, 1'b1, 1'b0, 8'h00},
		'{FILL_CONST,   8'hFF, 1'b1, 1'b0, 8'h00},
		'{FILL_CONST,   8'hFF, 1'b1, 1'b0, 8'h00},
		'{FILL_CONST,   8'hFF, 1'b1, 1'b1, 8'hFF},
		'{FILL_CONST,   8'h00, 1'b0, 1'b0, 8'h00},
		'{FILL_RAMP,    8'h01, 1'b0, 1'b0, 8'h00},
		'{FILL_CHECKER, 8'h55, 1'b0, 1'b0, 8'h00}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [DATA_W-1:0] pixel_value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DATA_W-1:0] average_value;
	logic [POS_W-1:0]  pixel_position;
	logic              line_end;

	// bench copy of the frame ring
	logic [DATA_W-1:0] hist [FRAMES][PIXELS];
	int unsigned       ring_slot = 0;
	int unsigned       frames_done = 0;
	int unsigned       pos_ctr = 0;

	result_t avg_queue [$];
	int      sent = 0;
	int      checked = 0;
	int      errors = 0;
	bit      src_calm = 1'b0;
	bit      sink_calm = 1'b0;
	bit      stall_req = 1'b0;

	multi_frame_pixel_averager #(
		.PIXELS(PIXELS),
		.FRAMES(FRAMES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_value   (pixel_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.average_value (average_value),
		.pixel_position(pixel_position),
		.line_end      (line_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#3_000_000;
		$display("timeout: %0d pixels sent, %0d averages pending", sent, avg_queue.size());
		$display("multi_frame_pixel_averager regression: fail");
		$finish;
	end

	// store one pixel in the ring and form its average once the ring is full
	function automatic void absorb_pixel(input logic [DATA_W-1:0] v, output bit made,
			output result_t r);
		int unsigned sum;
		int          f;
		hist[ring_slot][pos_ctr] = v;
		made = (frames_done >= FRAMES - 1);
		sum = 0;
		for (f = 0; f < FRAMES; f++)
			if (made)
				sum += hist[f][pos_ctr];
		r.avg  = DATA_W'(sum / FRAMES);
		r.pos  = POS_W'(pos_ctr);
		r.last = (pos_ctr == PIXELS - 1);
		if (r.last) begin
			pos_ctr = 0;
			ring_slot = (ring_slot + 1) % FRAMES;
			if (frames_done < FRAMES)
				frames_done++;
		end else begin
			pos_ctr++;
		end
	endfunction

	function automatic logic [DATA_W-1:0] plan_pixel(input frame_row_t row, input int p);
		case (row.kind)
			FILL_RAMP:    plan_pixel = DATA_W'(p * 2) + row.val;
			FILL_CHECKER: plan_pixel = p[0] ? ~row.val : row.val;
			default:      plan_pixel = row.val;
		endcase
	endfunction

	task automatic src_gap();
		if (!src_calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			pixel_value <= DATA_W'($urandom);
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_pixel(input logic [DATA_W-1:0] v, input bit typed, input bit emits,
			input logic [DATA_W-1:0] avg);
		bit      made;
		result_t r;
		in_valid <= 1'b1;
		pixel_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		absorb_pixel(v, made, r);
		if (typed) begin
			made = emits;
			r.avg = avg;
		end
		if (made)
			avg_queue.push_back(r);
		sent++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		wait (avg_queue.size() == 0);
		@(posedge clk);
	endtask

	function automatic void note_error(input string what, input result_t want);
		errors++;
		if (errors <= 10)
			$display("%t %s: want avg=%0d pos=%0d last=%0d, got avg=%0d pos=%0d last=%0d",
				$realtime, what, want.avg, want.pos, want.last,
				average_value, pixel_position, line_end);
	endfunction

	// output side: random ready bursts, plus one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			if (stall_req) begin
				stall_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (avg_queue.size() == 0) begin
				want = '0;
				note_error("unexpected transaction", want);
			end else begin
				want = avg_queue.pop_front();
				if (average_value !== want.avg || pixel_position !== want.pos ||
						line_end !== want.last)
					note_error("mismatch", want);
				checked++;
			end
		end
	end

	initial begin : stimulus
		int                r;
		int                p;
		int                n;
		int                mode;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] v;
		mode = 0;
		base = '0;
		wait (arst_n);
		@(posedge clk);

		for (r = 0; r < N_ROWS; r++) begin
			src_calm = (r == 1);
			sink_calm = (r == 1);
			// averages of the sixth frame meet a long output hold-off, so the pipe backs up
			if (r == 5)
				stall_req = 1'b1;
			for (p = 0; p < PIXELS; p++) begin
				src_gap();
				send_pixel(plan_pixel(frame_plan[r], p), frame_plan[r].typed,
					frame_plan[r].emits, frame_plan[r].avg);
			end
		end
		hold_until_drained();

		for (n = 0; n < RAND_ITEMS; n++) begin
			if (pos_ctr == 0) begin
				mode = $urandom_range(0, 3);
				base = DATA_W'($urandom);
				src_calm = ($urandom_range(0, 3) == 0);
				sink_calm = ($urandom_range(0, 3) == 0);
			end
			if (n == RAND_ITEMS / 2)
				hold_until_drained();
			if (n >= RAND_ITEMS - CALM_TAIL) begin
				src_calm = 1'b1;
				sink_calm = 1'b1;
			end
			case (mode)
				1:       v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				2:       v = base ^ DATA_W'($urandom_range(0, 3));
				3:       v = 8'h01 << $urandom_range(0, 7);
				default: v = DATA_W'($urandom);
			endcase
			src_gap();
			send_pixel(v, 1'b0, 1'b0, 8'h00);
		end
		in_valid <= 1'b0;

		wait (avg_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (avg_queue.size() != 0)
			errors++;

		$display("covered %0d pixels: warm-up, full-scale and patterned frames, line wraps,",
			sent);
		$display("held-off output and random frames; %0d averages checked, %0d errors",
			checked, errors);
		if (errors == 0)
			$display("multi_frame_pixel_averager regression: pass");
		else
			$display("multi_frame_pixel_averager regression: fail");
		$finish;
	end

endmodule

// File: multi_frame_pixel_averager.f
sv/fmpa_pkg.sv
sv/fmpa_ram.sv
sv/fmpa_div.sv
sv/fmpa_fifo.sv
sv/multi_frame_pixel_averager.sv
tb/tb_multi_frame_pixel_averager.sv
